### hdl/ers_pkg.sv
// ----------------------------------------------------------------------------
// ers_pkg
// Shared types and constants for the enumeration rank sorter: beat formats
// of both channels, the front-to-back queue entry and queue status.
// ----------------------------------------------------------------------------
package ers_pkg;

	// Default block capacity and queue depth
	localparam int MAX_ITEMS_DEF = 64;
	localparam int QUEUE_DEPTH   = 4;
	localparam int VALUE_W       = 32;

	// Input beat: one element of the block
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} item_t;

	// Output beat: one sorted element
	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      end_of_run;
		logic                      dropped;
	} result_t;

	// Work handed from front to back
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      store;    // value goes into the cell row
		logic                      close;    // block ends with this entry
		logic                      dropped;  // block lost elements (valid with close)
	} q_entry_t;

	// Queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### hdl/ers_front.sv
// ----------------------------------------------------------------------------
// ers_front
// Accepts input beats, counts the open block, drops elements beyond capacity
// and queues store / close work for the back end.
// ----------------------------------------------------------------------------
module ers_front #(
	parameter int MAX_ITEMS = ers_pkg::MAX_ITEMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  ers_pkg::item_t   item,
	input  ers_pkg::q_stat_t qstat,
	output logic             push,
	output ers_pkg::q_entry_t entry
);

	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          accept;
	logic          store;

	// Handshake and classification
	assign item_stall = qstat.full;
	assign accept     = item_valid && !item_stall;
	assign store      = count_q < CW'(MAX_ITEMS);
	assign push       = accept && (store || item.last);

	always_comb begin
		entry.value   = item.value;
		entry.store   = store;
		entry.close   = item.last;
		entry.dropped = ovf_q || !store;
	end

	// Open-block fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (item.last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (store) begin
				count_q <= count_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

### hdl/ers_fifo.sv
// ----------------------------------------------------------------------------
// ers_fifo
// Short queue between front and back; lets either side stall on its own.
// ----------------------------------------------------------------------------
module ers_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ers_pkg::q_entry_t  wr_entry,
	input  logic               pop,
	output ers_pkg::q_entry_t  rd_entry,
	output ers_pkg::q_stat_t   qstat
);

	localparam int D  = ers_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(D);
	localparam int DW = $clog2(D + 1);

	ers_pkg::q_entry_t mem_q [D];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [DW-1:0]     cnt_q;

	assign rd_entry    = mem_q[rd_q];
	assign qstat.full  = cnt_q == DW'(D);
	assign qstat.empty = cnt_q == '0;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_entry;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + DW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - DW'(1);
			end
		end
	end

endmodule

### hdl/ers_back.sv
// ----------------------------------------------------------------------------
// ers_back
// Row of rank cells kept in ascending order. Each stored value is placed at
// its rank as it arrives (cells holding larger values move up one place, so
// equal values keep arrival order); on close the row drains from cell 0.
// ----------------------------------------------------------------------------
module ers_back #(
	parameter int MAX_ITEMS = ers_pkg::MAX_ITEMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ers_pkg::q_entry_t             entry,
	input  ers_pkg::q_stat_t              qstat,
	output logic                          pop,
	output logic                          result_valid,
	input  logic                          result_stall,
	output ers_pkg::result_t              result,
	output logic                          draining,
	output logic [$clog2(MAX_ITEMS+1)-1:0] fill
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int VW = ers_pkg::VALUE_W;

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                 state_q;
	logic [CW-1:0]        cnt_q;
	logic                 drop_q;
	logic                 out_valid_q;
	ers_pkg::result_t     out_q;
	logic signed [VW-1:0] cell_q [MAX_ITEMS];
	logic signed [VW-1:0] ins    [MAX_ITEMS];
	logic signed [VW-1:0] shl    [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] gt;
	logic                 take;
	logic                 shift;

	assign pop          = (state_q == ST_LOAD) && !qstat.empty;
	assign take         = !out_valid_q || !result_stall;
	assign shift        = (state_q == ST_DRAIN) && take;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign draining     = state_q == ST_DRAIN;
	assign fill         = cnt_q;

	// Per-cell compare against the arriving value; empty cells count as larger
	always_comb begin
		for (int k = 0; k < MAX_ITEMS; k++) begin
			gt[k] = (CW'(k) >= cnt_q) || (cell_q[k] > entry.value);
		end
	end

	// Next value of each cell for insert and for drain
	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign ins[k] = gt[k] ? entry.value : cell_q[k];
		end else begin : g_body
			assign ins[k] = gt[k] ? (gt[k-1] ? cell_q[k-1] : entry.value) : cell_q[k];
		end
		if (k == MAX_ITEMS - 1) begin : g_tail
			assign shl[k] = cell_q[k];
		end else begin : g_mid
			assign shl[k] = cell_q[k+1];
		end

		always_ff @(posedge clk) begin
			if (pop && entry.store) begin
				cell_q[k] <= ins[k];
			end else if (shift) begin
				cell_q[k] <= shl[k];
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (shift) begin
			out_q.sorted_value <= cell_q[0];
			out_q.end_of_run   <= cnt_q == CW'(1);
			out_q.dropped      <= drop_q;
		end
	end

	// Load / drain sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Output beat: loaded by a drain step, cleared once taken
			if (shift) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (entry.store) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (entry.close) begin
							drop_q  <= entry.dropped;
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (take) begin
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

### hdl/enumeration_rank_sort.sv
// ----------------------------------------------------------------------------
// enumeration_rank_sort
// Sorts one block of signed 32-bit values per closing beat and streams the
// block back in ascending order, equal values in arrival order.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  item     | item_valid/item_stall  | value, last
//  result   | result_valid/result_st.| sorted_value, end_of_run, dropped
//
//  Each element is placed in the cell row on insert and leaves it as one
//  beat on drain; the single cell row limits throughput, as loading stops
//  while it drains. The front keeps accepting into the queue meanwhile
//  until the queue fills. Reset clears counts, flags and the queue; cell
//  contents are not reset. A stalled result beat holds in the output
//  register.
// ----------------------------------------------------------------------------
module enumeration_rank_sort #(
	parameter int MAX_ITEMS = ers_pkg::MAX_ITEMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  ers_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output ers_pkg::result_t result
);

	localparam int CW = $clog2(MAX_ITEMS + 1);

	ers_pkg::q_entry_t wr_entry;
	ers_pkg::q_entry_t rd_entry;
	ers_pkg::q_stat_t  qstat;
	logic              push;
	logic              pop;
	logic              draining;
	logic [CW-1:0]     fill;

	ers_front #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.qstat     (qstat),
		.push      (push),
		.entry     (wr_entry)
	);

	ers_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.rd_entry(rd_entry),
		.qstat   (qstat)
	);

	ers_back #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (rd_entry),
		.qstat       (qstat),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.draining    (draining),
		.fill        (fill)
	);

	// Queue never written when full, never read when empty
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue pop while empty");

	// A draining row always holds at least one element
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		draining |-> fill != '0)
		else $error("drain with empty cell row");

	// Cell row never holds more than its capacity
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= CW'(MAX_ITEMS))
		else $error("cell row overfilled");

endmodule
